// ----- design/rrqm_pkg.sv -----
// shared types and constants for the round-robin queue merge unit
// no dependencies; imported by rrqm_ctrl, rrqm_datapath and the top level
package rrqm_pkg;

  localparam int DATA_W   = 32;
  localparam int SEL_W    = 2;
  localparam int STATUS_W = 2;

  // action codes of an input transaction
  localparam logic ACTION_PUSH = 1'b0;
  localparam logic ACTION_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_PUSHED  = 2'd0,
    STAT_DROPPED = 2'd1,
    STAT_POPPED  = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } ctrl_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the incoming transaction
    logic exec;    // do the queue access and update counters
    logic finish;  // load the result registers
  } ctrl_cmd_t;

endpackage

// ----- design/rrqm_ram.sv -----
// generic simple dual-port ram with registered read
// no dependencies
module rrqm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/rrqm_ctrl.sv -----
// controller state machine: sequences accept, execute and result capture
// depends on rrqm_pkg
module rrqm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               strobe,
  output rrqm_pkg::ctrl_cmd_t cmd
);
  import rrqm_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= cmd.finish;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/rrqm_datapath.sv -----
// datapath: per-queue counters, round-robin search, queue memory, result registers
// depends on rrqm_pkg and rrqm_ram
module rrqm_datapath #(
  parameter int NUM_QUEUES  = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rrqm_pkg::ctrl_cmd_t               cmd,
  input  logic                              action,
  input  logic [rrqm_pkg::SEL_W-1:0]        queue_sel,
  input  logic signed [rrqm_pkg::DATA_W-1:0] data_in,
  output logic [rrqm_pkg::STATUS_W-1:0]     status,
  output logic signed [rrqm_pkg::DATA_W-1:0] data_out,
  output logic [rrqm_pkg::SEL_W-1:0]        source_queue,
  output logic                              more_left
);
  import rrqm_pkg::*;

  localparam int QW = $clog2(NUM_QUEUES);
  localparam int SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = QW + SW;
  localparam int RAM_DEPTH = NUM_QUEUES << SW;

  // captured transaction
  logic              act;
  logic [SEL_W-1:0]  sel;
  logic [DATA_W-1:0] din;

  // per-queue bookkeeping
  logic [SW-1:0] wr_slot [NUM_QUEUES];
  logic [SW-1:0] rd_slot [NUM_QUEUES];
  logic [FW-1:0] fill    [NUM_QUEUES];
  logic [QW-1:0] turn;
  logic [NUM_QUEUES-1:0] nonempty;

  status_t       stat;
  logic [QW-1:0] src;

  logic [QW-1:0] sel_idx;
  logic          sel_ok;
  logic          push_ok;
  logic          hit;
  logic [QW-1:0] hit_q;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action;
      sel <= queue_sel;
      din <= data_in;
    end
  end

  always_comb begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      nonempty[q] = (fill[q] != '0);
    end
  end

  assign sel_idx = QW'(sel);
  assign sel_ok  = (32'(sel) < 32'(NUM_QUEUES));
  assign push_ok = sel_ok && (fill[sel_idx] != FW'(QUEUE_DEPTH));

  // rotating priority search from the turn pointer
  always_comb begin
    logic [QW:0] idx;
    hit   = 1'b0;
    hit_q = '0;
    for (int k = 0; k < NUM_QUEUES; k++) begin
      idx = (QW+1)'(turn) + (QW+1)'(k);
      if (idx >= (QW+1)'(NUM_QUEUES)) begin
        idx = idx - (QW+1)'(NUM_QUEUES);
      end
      if (!hit && nonempty[idx[QW-1:0]]) begin
        hit   = 1'b1;
        hit_q = idx[QW-1:0];
      end
    end
  end

  assign ram_we    = cmd.exec && (act == ACTION_PUSH) && push_ok;
  assign ram_waddr = {sel_idx, wr_slot[sel_idx]};
  assign ram_raddr = {hit_q, rd_slot[hit_q]};

  rrqm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(din),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        wr_slot[q] <= '0;
        rd_slot[q] <= '0;
        fill[q]    <= '0;
      end
      turn <= '0;
    end else if (cmd.exec) begin
      if (act == ACTION_PUSH) begin
        if (push_ok) begin
          wr_slot[sel_idx] <= (wr_slot[sel_idx] == SW'(QUEUE_DEPTH - 1)) ? '0
                              : wr_slot[sel_idx] + 1'b1;
          fill[sel_idx]    <= fill[sel_idx] + 1'b1;
        end
      end else if (hit) begin
        rd_slot[hit_q] <= (rd_slot[hit_q] == SW'(QUEUE_DEPTH - 1)) ? '0
                          : rd_slot[hit_q] + 1'b1;
        fill[hit_q]    <= fill[hit_q] - 1'b1;
        turn           <= (hit_q == QW'(NUM_QUEUES - 1)) ? '0 : hit_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      src <= hit_q;
      if (act == ACTION_PUSH) begin
        stat <= push_ok ? STAT_PUSHED : STAT_DROPPED;
      end else begin
        stat <= hit ? STAT_POPPED : STAT_EMPTY;
      end
    end
  end

  // memory read data is valid in the cycle after exec
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status       <= stat;
      data_out     <= (stat == STAT_POPPED) ? $signed(ram_rdata) : '0;
      source_queue <= (stat == STAT_POPPED) ? SEL_W'(src) : '0;
      more_left    <= |nonempty;
    end
  end

endmodule

// ----- design/round_robin_queue_merge_unit.sv -----
// top level of the round-robin queue merge unit
// depends on rrqm_pkg, rrqm_ctrl, rrqm_datapath (which holds rrqm_ram)

// A transaction is taken when start is high and busy is low. A push
// (action 0) appends data_in to queue queue_sel, or drops it when that queue
// is full or does not exist; a pop (action 1) takes the head of the first
// non-empty queue at or after the round-robin pointer and moves the pointer
// past it. Every transaction yields exactly one result, shown for one cycle
// with strobe high; the receiver cannot stall, so it must take each result
// in that cycle. A transaction passes through a capture phase, an
// execute phase that updates the queue counters and drives the queue
// memory, and a phase that waits for the registered memory read before the
// result registers load. strobe rises in the cycle busy drops, so the next
// start may come together with the previous result. Queue memory needs no
// clearing after reset: only data from occupied slots is ever used.
module round_robin_queue_merge_unit #(
  parameter int NUM_QUEUES  = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // command side
  input  logic                               start,
  output logic                               busy,
  input  logic                               action,
  input  logic [rrqm_pkg::SEL_W-1:0]         queue_sel,
  input  logic signed [rrqm_pkg::DATA_W-1:0] data_in,
  // result side
  output logic                               strobe,
  output logic [rrqm_pkg::STATUS_W-1:0]      status,
  output logic signed [rrqm_pkg::DATA_W-1:0] data_out,
  output logic [rrqm_pkg::SEL_W-1:0]         source_queue,
  output logic                               more_left
);
  import rrqm_pkg::*;

  // command bundle between controller and datapath
  ctrl_cmd_t cmd;

  // sequencing: idle -> exec -> done -> idle
  rrqm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .strobe(strobe),
    .cmd   (cmd)
  );

  // counters, round-robin search, queue memory and result registers
  rrqm_datapath #(
    .NUM_QUEUES (NUM_QUEUES),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .action      (action),
    .queue_sel   (queue_sel),
    .data_in     (data_in),
    .status      (status),
    .data_out    (data_out),
    .source_queue(source_queue),
    .more_left   (more_left)
  );

  // an accepted transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // each result strobe follows a finish command and nothing else
  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(cmd.finish))
    else $error("result strobe without finish command");

  // queue work only happens while busy
  a_exec_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> busy)
    else $error("execute command while idle");

  // non-pop results carry zero data and zero source
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (strobe && status != STAT_POPPED) |-> (data_out == '0 && source_queue == '0))
    else $error("nonzero payload on non-pop result");

endmodule
